// ----- rtl/core/palette_quantize_pack_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Palette quantize pack unit assertion macros
// Shared concurrent assertion wrappers for the checker of the block.
// ----------------------------------------------------------------------------
`ifndef PALETTE_QUANTIZE_PACK_UNIT_MACROS_SVH
`define PALETTE_QUANTIZE_PACK_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define PQP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("palette_quantize_pack_unit: assertion failed");

// Assertion that is also checked across reset.
`define PQP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("palette_quantize_pack_unit: assertion failed");

`endif

// ----- rtl/core/pqp_pkg.sv -----
// ----------------------------------------------------------------------------
// Palette quantize pack package
// Types, register indexes, reset values and the square root step.
// ----------------------------------------------------------------------------
package pqp_pkg;

   typedef logic [23:0] colour_type;
   typedef logic [17:0] dist_sq_type;

   typedef enum logic [1:0] {
      MODE_INDEX_BYTE = 2'd0,
      MODE_INDEX_PAIR = 2'd1,
      MODE_NONZERO_BIT = 2'd2,
      MODE_RED_BIT = 2'd3
   } pack_mode_type;

   // Configuration register indexes.
   localparam logic [2:0] REG_PALETTE_ZERO = 3'd0;
   localparam logic [2:0] REG_PALETTE_ONE = 3'd1;
   localparam logic [2:0] REG_PALETTE_TWO = 3'd2;
   localparam logic [2:0] REG_PALETTE_THREE = 3'd3;
   localparam logic [2:0] REG_PACK_MODE = 3'd4;

   localparam int unsigned NUM_ENTRIES = 4;

   // Entry 3 first: packed arrays list the highest index on the left.
   localparam colour_type [NUM_ENTRIES-1:0] PALETTE_RESET = {
      24'h7F7F7F, 24'h000000, 24'hFFFFFF, 24'hBFBFBF
   };

   localparam logic [7:0] RED_THRESHOLD = 8'd128;

   // Work item handed from the front to the back through the queue.
   typedef struct packed {
      logic [1:0] idx;
      logic red_hi;
      logic group_end;
   } token_type;

   // Partial state of the digit-by-digit square root.
   typedef struct packed {
      dist_sq_type v;
      dist_sq_type r;
   } root_state_type;

   // Three consecutive root steps, the first with trial bit 4**top_k.
   function automatic root_state_type sqrt_steps3(root_state_type s, int top_k);
      root_state_type st;
      dist_sq_type bit_val;
      logic [18:0] trial;
      st = s;
      for (int j = 0; j < 3; j++) begin
         bit_val = dist_sq_type'(1) << (2 * (top_k - j));
         trial = {1'b0, st.r} + {1'b0, bit_val};
         if ({1'b0, st.v} >= trial) begin
            st.v = st.v - trial[17:0];
            st.r = (st.r >> 1) + bit_val;
         end else begin
            st.r = st.r >> 1;
         end
      end
      return st;
   endfunction

endpackage

// ----- rtl/core/pqp_req_if.sv -----
// ----------------------------------------------------------------------------
// Palette quantize pack request channel
// Valid/ready channel carrying one RGB pixel per request.
// ----------------------------------------------------------------------------
interface pqp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       group_end;

   modport source (output valid, output red, output green, output blue,
                   output group_end, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input group_end, output ready);
endinterface

// ----- rtl/core/pqp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Palette quantize pack response channel
// Valid/ready channel carrying one encoded byte per transfer.
// ----------------------------------------------------------------------------
interface pqp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       group_last;

   modport source (output valid, output out_byte, output group_last, input ready);
   modport sink (input valid, input out_byte, input group_last, output ready);
endinterface

// ----- rtl/core/pqp_front.sv -----
// ----------------------------------------------------------------------------
// Palette quantize pack front
// Five stage pipeline: distances, squares, root and nearest entry choice.
// ----------------------------------------------------------------------------
module pqp_front (
   input  logic                                             clock,
   input  logic                                             reset,
   input  pqp_pkg::colour_type [pqp_pkg::NUM_ENTRIES-1:0]   palette,
   pqp_req_if.sink                                          req,
   output logic                                             push_valid,
   input  logic                                             push_ready,
   output pqp_pkg::token_type                               push_token
);

   localparam int unsigned N = pqp_pkg::NUM_ENTRIES;

   typedef struct packed {
      logic [N-1:0][2:0][7:0] diff;
      logic red_hi;
      logic group_end;
   } diff_stage_type;

   typedef struct packed {
      pqp_pkg::root_state_type [N-1:0] root;
      logic red_hi;
      logic group_end;
   } root_stage_type;

   logic en;
   logic [4:0] valid_ff, valid_in;
   diff_stage_type s1_ff, s1_in;
   root_stage_type s2_ff, s2_in, s3_ff, s3_in, s4_ff, s4_in, s5_ff, s5_in;

   // The whole pipeline holds when its last stage cannot hand over.
   assign en = !valid_ff[4] || push_ready;
   assign req.ready = en;
   assign valid_in = {valid_ff[3:0], req.valid};

   always_comb begin
      logic [7:0] pix [3];
      logic [7:0] pal;
      pix[0] = req.red;
      pix[1] = req.green;
      pix[2] = req.blue;
      s1_in.red_hi = req.red > pqp_pkg::RED_THRESHOLD;
      s1_in.group_end = req.group_end;
      for (int n = 0; n < N; n++) begin
         for (int c = 0; c < 3; c++) begin
            pal = palette[n][8*(2-c) +: 8];
            s1_in.diff[n][c] = (pal > pix[c]) ? pal - pix[c] : pix[c] - pal;
         end
      end
   end

   always_comb begin
      logic [15:0] sq [3];
      s2_in.red_hi = s1_ff.red_hi;
      s2_in.group_end = s1_ff.group_end;
      for (int n = 0; n < N; n++) begin
         for (int c = 0; c < 3; c++) begin
            sq[c] = 16'(s1_ff.diff[n][c]) * 16'(s1_ff.diff[n][c]);
         end
         s2_in.root[n].v = 18'(sq[0]) + 18'(sq[1]) + 18'(sq[2]);
         s2_in.root[n].r = '0;
      end
   end

   // Nine root steps in three stages; the sum stays below 4**9.
   always_comb begin
      s3_in = s2_ff;
      s4_in = s3_ff;
      s5_in = s4_ff;
      for (int n = 0; n < N; n++) begin
         s3_in.root[n] = pqp_pkg::sqrt_steps3(s2_ff.root[n], 8);
         s4_in.root[n] = pqp_pkg::sqrt_steps3(s3_ff.root[n], 5);
         s5_in.root[n] = pqp_pkg::sqrt_steps3(s4_ff.root[n], 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   // Strictly smaller root replaces the best, so the lower entry wins ties.
   always_comb begin
      logic [8:0] best_root;
      logic [1:0] best_idx;
      best_idx = '0;
      best_root = s5_ff.root[0].r[8:0];
      for (int n = 1; n < N; n++) begin
         if (s5_ff.root[n].r[8:0] < best_root) begin
            best_root = s5_ff.root[n].r[8:0];
            best_idx = 2'(n);
         end
      end
      push_token.idx = best_idx;
      push_token.red_hi = s5_ff.red_hi;
      push_token.group_end = s5_ff.group_end;
   end

   assign push_valid = valid_ff[4];

endmodule

// ----- rtl/core/pqp_queue.sv -----
// ----------------------------------------------------------------------------
// Palette quantize pack queue
// Small register FIFO of tokens between the front and the back.
// ----------------------------------------------------------------------------
module pqp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  pqp_pkg::token_type push_token,
   output logic               pop_valid,
   input  logic               pop,
   output pqp_pkg::token_type pop_token
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pqp_pkg::token_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic full, do_push, do_pop;

   assign full = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign push_ready = !full || pop;
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;
   assign pop_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// ----- rtl/core/pqp_back.sv -----
// ----------------------------------------------------------------------------
// Palette quantize pack back
// Bit packer and response register.
// ----------------------------------------------------------------------------
module pqp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  pqp_pkg::pack_mode_type mode,
   input  logic                   tok_valid,
   input  pqp_pkg::token_type     tok,
   output logic                   pop,
   pqp_rsp_if.source              rsp
);

   logic [7:0] buffer_ff, buffer_in;
   logic [2:0] pos_ff, pos_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic [1:0] bits;
   logic [3:0] step;
   logic [9:0] shifted;
   logic [7:0] merged;
   logic [3:0] new_pos;
   logic       emit;

   assign pop = tok_valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      unique case (mode)
         pqp_pkg::MODE_INDEX_BYTE: begin
            bits = tok.idx;
            step = 4'd0;
         end
         pqp_pkg::MODE_INDEX_PAIR: begin
            bits = tok.idx;
            step = 4'd2;
         end
         pqp_pkg::MODE_NONZERO_BIT: begin
            bits = {1'b0, tok.idx != 2'd0};
            step = 4'd1;
         end
         pqp_pkg::MODE_RED_BIT: begin
            bits = {1'b0, tok.red_hi};
            step = 4'd1;
         end
         default: begin
            bits = '0;
            step = 4'd1;
         end
      endcase
   end

   // An index placed at the top bit loses its upper half.
   assign shifted = {8'b0, bits} << pos_ff;
   assign merged = buffer_ff | shifted[7:0];
   assign new_pos = {1'b0, pos_ff} + step;
   assign emit = (mode == pqp_pkg::MODE_INDEX_BYTE) || new_pos[3] || tok.group_end;

   always_comb begin
      buffer_in = buffer_ff;
      pos_in = pos_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (pop) begin
         if (mode == pqp_pkg::MODE_INDEX_BYTE) begin
            out_byte_in = {6'b0, tok.idx};
         end else begin
            out_byte_in = merged;
            if (emit) begin
               buffer_in = '0;
               pos_in = '0;
            end else begin
               buffer_in = merged;
               pos_in = new_pos[2:0];
            end
         end
         out_last_in = tok.group_end;
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff <= '0;
         pos_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         buffer_ff <= buffer_in;
         pos_ff <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.group_last = out_last_ff;

endmodule

// ----- rtl/core/palette_quantize_pack_unit.sv -----
// ----------------------------------------------------------------------------
// Palette quantize pack unit
// Nearest of four palette colours per pixel, packed into bytes.
// ----------------------------------------------------------------------------
// Each request on req carries one RGB pixel and a group_end flag. The unit
// picks the palette entry with the smallest integer root distance, the lower
// entry winning on equal roots, and encodes it by the pack mode: one byte per
// index, four 2-bit indices per byte, or one bit per pixel (nonzero index or
// red above 128). Bytes fill from the least significant bit; group_end
// flushes a partial byte and marks the byte with group_last.
// The csr port writes the four palette colours and the pack mode; it should
// only be written while no pixel is in flight.
// A pixel that yields a byte reaches rsp through five front stages
// (distances, squares, three root stages), the token queue and the
// response register. One pixel is accepted every cycle while req.ready
// is high. When rsp stalls, the queue fills, then the whole front holds
// and req.ready falls; nothing is lost. Reset restores the default palette
// and byte mode and empties the pack buffer, the queue and the pipeline.
// ----------------------------------------------------------------------------
module palette_quantize_pack_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   pqp_req_if.sink     req,
   pqp_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   pqp_pkg::colour_type [pqp_pkg::NUM_ENTRIES-1:0] palette_ff, palette_in;
   pqp_pkg::pack_mode_type mode_ff, mode_in;

   logic               push_valid;
   logic               push_ready;
   pqp_pkg::token_type push_token;
   logic               tok_valid;
   pqp_pkg::token_type tok;
   logic               pop;

   // Register file; indexes beyond the pack mode are ignored.
   always_comb begin
      palette_in = palette_ff;
      mode_in = mode_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pqp_pkg::REG_PALETTE_ZERO: palette_in[0] = csr_wdata;
            pqp_pkg::REG_PALETTE_ONE: palette_in[1] = csr_wdata;
            pqp_pkg::REG_PALETTE_TWO: palette_in[2] = csr_wdata;
            pqp_pkg::REG_PALETTE_THREE: palette_in[3] = csr_wdata;
            pqp_pkg::REG_PACK_MODE: mode_in = pqp_pkg::pack_mode_type'(csr_wdata[1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= pqp_pkg::PALETTE_RESET;
         mode_ff <= pqp_pkg::MODE_INDEX_BYTE;
      end else begin
         palette_ff <= palette_in;
         mode_ff <= mode_in;
      end
   end

   // The front classifies pixels into tokens of index and flags.
   pqp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .palette    (palette_ff),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_token (push_token)
   );

   // The queue lets the front run on while the back waits on rsp.
   pqp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_token (push_token),
      .pop_valid  (tok_valid),
      .pop        (pop),
      .pop_token  (tok)
   );

   // The back packs tokens into bytes and holds the response register.
   pqp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .tok_valid (tok_valid),
      .tok       (tok),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

// ----- rtl/core/pqp_checker.sv -----
// ----------------------------------------------------------------------------
// Palette quantize pack checker
// Port level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "palette_quantize_pack_unit_macros.svh"

module pqp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_group_last
);

   // A stalled response keeps its byte and flag.
   `PQP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_group_last))

   // Requests are only refused while a response is being held back.
   `PQP_ASSERT(a_req_stall_cause, clock, reset, !req_ready |-> rsp_valid && !rsp_ready)

   // Reset empties the response register.
   `PQP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind palette_quantize_pack_unit pqp_checker u_pqp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_out_byte   (rsp.out_byte),
   .rsp_group_last (rsp.group_last)
);

// ----- bench/palette_quantize_pack_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Palette quantize pack unit testbench
// Streams RGB pixels through the unit under a series of palette and pack
// mode settings. A behavioural model predicts every encoded byte, and a
// monitor checks each byte and its group_last flag in order.
// ----------------------------------------------------------------------------
module palette_quantize_pack_unit_test;

   // One pixel request as the driver presents it.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       group_end;
   } pixel_item_type;

   // One encoded byte as the unit should return it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       group_last;
   } coded_byte_type;

   localparam int unsigned RANDOM_PIXELS = 1250;
   // The drain margin covers the front pipeline, the queue and the
   // response register before a register write is allowed.
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;

   pqp_req_if req_if ();
   pqp_rsp_if rsp_if ();

   palette_quantize_pack_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Pixels waiting for the driver, and bytes that the model has predicted
   // but the unit has not yet returned.
   pixel_item_type pending_pixels[$];
   coded_byte_type expected_bytes[$];

   // The model's own copy of the registers and the packing state.
   pqp_pkg::colour_type    palette_model [pqp_pkg::NUM_ENTRIES];
   pqp_pkg::pack_mode_type mode_model;
   logic [7:0]             pack_buf_model;
   int unsigned            bit_pos_model;

   int unsigned cycle_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned bytes_checked = 0;
   int unsigned groups_closed = 0;
   int unsigned fail_count = 0;
   int unsigned phase_count = 0;

   // Exact floor of the square root, found one result bit at a time from
   // the top: a bit is kept if its square still fits under the value.
   function automatic logic [8:0] floor_root(input logic [17:0] value);
      logic [8:0]  root;
      int unsigned trial;
      root = '0;
      for (int b = 8; b >= 0; b--) begin
         trial = root | (9'd1 << b);
         if (trial * trial <= value) begin
            root = trial[8:0];
         end
      end
      return root;
   endfunction

   // Palette entry with the smallest root distance. A later entry only
   // takes over on a strictly smaller root, so the lowest entry wins ties.
   function automatic logic [1:0] nearest_colour(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
      logic [1:0]  best;
      logic [8:0]  best_root;
      logic [8:0]  root;
      int          dr;
      int          dg;
      int          db;
      best = '0;
      best_root = '0;
      for (int n = 0; n < pqp_pkg::NUM_ENTRIES; n++) begin
         dr = int'(palette_model[n][23:16]) - int'(r);
         dg = int'(palette_model[n][15:8]) - int'(g);
         db = int'(palette_model[n][7:0]) - int'(b);
         root = floor_root(18'(dr * dr + dg * dg + db * db));
         if (n == 0 || root < best_root) begin
            best = 2'(n);
            best_root = root;
         end
      end
      return best;
   endfunction

   // Advances the packing model by one accepted pixel and queues the byte
   // that it produces, if any.
   task automatic encode_pixel(input pixel_item_type px);
      logic [1:0]  idx;
      logic [7:0]  bits;
      int unsigned step;
      int unsigned next_pos;
      idx = nearest_colour(px.red, px.green, px.blue);
      if (mode_model == pqp_pkg::MODE_INDEX_BYTE) begin
         // Byte mode passes the packing state through untouched.
         expected_bytes.insert(expected_bytes.size(), '{{6'd0, idx}, px.group_end});
      end else begin
         case (mode_model)
            pqp_pkg::MODE_INDEX_PAIR: begin
               bits = {6'd0, idx};
               step = 2;
            end
            pqp_pkg::MODE_NONZERO_BIT: begin
               bits = {7'd0, idx != 2'd0};
               step = 1;
            end
            default: begin
               bits = {7'd0, px.red > pqp_pkg::RED_THRESHOLD};
               step = 1;
            end
         endcase
         // Any bit shifted past bit 7 falls off the 8-bit buffer.
         pack_buf_model = pack_buf_model | (bits << bit_pos_model);
         next_pos = bit_pos_model + step;
         if (next_pos >= 8 || px.group_end) begin
            expected_bytes.insert(expected_bytes.size(), '{pack_buf_model, px.group_end});
            pack_buf_model = '0;
            bit_pos_model = 0;
         end else begin
            bit_pos_model = next_pos;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Pixels go out in bursts of random length separated by
   // random gaps; one gap in four is left out, so bursts then run back to back.
   // The model is advanced at the edge on which each request is accepted.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_pixels
      pixel_item_type px;
      logic           next_valid;
      int unsigned    gap_left;
      int unsigned    burst_left;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
         burst_left = 1;
      end else begin
         next_valid = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            encode_pixel('{req_if.red, req_if.green, req_if.blue, req_if.group_end});
            pixels_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_pixels.size() != 0) begin
               px = pending_pixels.pop_front();
               req_if.red <= px.red;
               req_if.green <= px.green;
               req_if.blue <= px.blue;
               req_if.group_end <= px.group_end;
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end else begin
                  burst_left--;
               end
            end
         end
         // A single assignment per edge keeps valid steady across bursts.
         req_if.valid <= next_valid;
      end
   end

   // ------------------------------------------------------------------------
   // Response back-pressure. Every so often a new stall style is picked:
   // always ready, mostly ready, mostly stalled, or a fixed periodic pattern,
   // so that stalls land on every stage of the pipeline and the queue fills.
   // ------------------------------------------------------------------------
   int unsigned stall_style = 0;
   int unsigned stall_timer = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_style <= 0;
         stall_timer <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 120);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_style)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ($urandom_range(0, 9) < 3);
            default: rsp_if.ready <= ((cycle_count % 5) < 2);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor. Every accepted byte is matched against the oldest
   // prediction; a byte with nothing predicted is itself a failure.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_bytes
      coded_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte %h group_last %b with nothing predicted",
                     $time, rsp_if.out_byte, rsp_if.group_last);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_if.group_last) begin
               groups_closed++;
            end
            if (rsp_if.out_byte !== want.out_byte) begin
               $display("%0t: out_byte mismatch: expected %h, actual %h",
                        $time, want.out_byte, rsp_if.out_byte);
               fail_count++;
            end
            if (rsp_if.group_last !== want.group_last) begin
               $display("%0t: group_last mismatch: expected %b, actual %b",
                        $time, want.group_last, rsp_if.group_last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Drives one register write. The model takes the new value at once,
   // which is safe because writes only happen while no pixel is in flight.
   task automatic csr_write(input logic [2:0] idx, input logic [23:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx) inside
         pqp_pkg::REG_PALETTE_ZERO, pqp_pkg::REG_PALETTE_ONE,
         pqp_pkg::REG_PALETTE_TWO, pqp_pkg::REG_PALETTE_THREE:
            palette_model[idx[1:0]] = value;
         pqp_pkg::REG_PACK_MODE:
            mode_model = pqp_pkg::pack_mode_type'(value[1:0]);
         default: ;
      endcase
   endtask

   task automatic csr_release();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every request has been taken and every predicted byte has
   // come back. A pixel that yields no byte may still be in the pipeline,
   // so the wait then runs on to let the pipeline drain. Sampling on the falling
   // edge avoids racing the driver's updates at the rising edge.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_if.valid || expected_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_pixel(input logic [23:0] rgb, input logic group_end);
      pending_pixels.insert(pending_pixels.size(),
                            '{rgb[23:16], rgb[15:8], rgb[7:0], group_end});
   endtask

   function automatic logic [7:0] jitter(input int base, input int span);
      int v;
      v = base + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) begin
         v = 0;
      end else if (v > 255) begin
         v = 255;
      end
      return 8'(v);
   endfunction

   function automatic logic [7:0] corner_level();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd127;
         3: return 8'd128;
         4: return 8'd129;
         default: return 8'($urandom);
      endcase
   endfunction

   // Random pixel: fully random, close to a palette entry, near the middle
   // of two entries where ties and near-ties live, or built from corner
   // levels around the red threshold.
   function automatic pixel_item_type random_pixel(input logic group_end);
      pixel_item_type px;
      int unsigned    ea;
      int unsigned    eb;
      ea = $urandom_range(0, 3);
      eb = $urandom_range(0, 3);
      px.group_end = group_end;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            px.red = 8'($urandom);
            px.green = 8'($urandom);
            px.blue = 8'($urandom);
         end
         4, 5, 6: begin
            px.red = jitter(palette_model[ea][23:16], 8);
            px.green = jitter(palette_model[ea][15:8], 8);
            px.blue = jitter(palette_model[ea][7:0], 8);
         end
         7, 8: begin
            px.red = jitter((palette_model[ea][23:16] + palette_model[eb][23:16]) / 2, 1);
            px.green = jitter((palette_model[ea][15:8] + palette_model[eb][15:8]) / 2, 1);
            px.blue = jitter((palette_model[ea][7:0] + palette_model[eb][7:0]) / 2, 1);
         end
         default: begin
            px.red = corner_level();
            px.green = corner_level();
            px.blue = corner_level();
         end
      endcase
      return px;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus. A directed opening covers each pack mode, the corner colours,
   // a full byte that also closes a group, partial flushes, a switch of mode
   // part way through a byte (including a 2-bit index at the top position,
   // whose upper bit is lost), byte mode leaving a partial byte alone, and
   // writes to unused register indexes. Random phases follow, each with its
   // own palette style, pack mode and group length.
   // ------------------------------------------------------------------------
   initial begin : run_stimulus
      pqp_pkg::colour_type pal [pqp_pkg::NUM_ENTRIES];
      int unsigned         random_sent;
      int unsigned         count;
      int unsigned         group_den;
      int unsigned         style;
      logic [2:0]          spare_idx;

      req_if.valid = 1'b0;
      req_if.red = '0;
      req_if.green = '0;
      req_if.blue = '0;
      req_if.group_end = 1'b0;
      rsp_if.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int n = 0; n < pqp_pkg::NUM_ENTRIES; n++) begin
         palette_model[n] = pqp_pkg::PALETTE_RESET[n];
      end
      mode_model = pqp_pkg::MODE_INDEX_BYTE;
      pack_buf_model = '0;
      bit_pos_model = 0;

      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default palette in byte mode: each reset colour picks its own entry.
      queue_pixel(24'h000000, 1'b0);
      queue_pixel(24'hFFFFFF, 1'b1);
      queue_pixel(24'hBFBFBF, 1'b0);
      queue_pixel(24'h7F7F7F, 1'b1);
      wait_drained();

      // Index pairs: a full byte closing a group, then a two-pixel flush.
      csr_write(pqp_pkg::REG_PACK_MODE, 24'(pqp_pkg::MODE_INDEX_PAIR));
      csr_release();
      queue_pixel(24'hFFFFFF, 1'b0);
      queue_pixel(24'h000000, 1'b0);
      queue_pixel(24'h7F7F7F, 1'b0);
      queue_pixel(24'hBFBFBF, 1'b1);
      queue_pixel(24'h7F7F7F, 1'b0);
      queue_pixel(24'hFFFFFF, 1'b1);
      wait_drained();

      // Red threshold: 128 itself stays clear, 129 sets the bit.
      csr_write(pqp_pkg::REG_PACK_MODE, 24'(pqp_pkg::MODE_RED_BIT));
      csr_release();
      queue_pixel(24'h80FFFF, 1'b0);
      queue_pixel(24'h810000, 1'b0);
      queue_pixel(24'h00FFFF, 1'b0);
      queue_pixel(24'hFF0000, 1'b1);
      wait_drained();

      // Three single bits, then index pairs carry on to position 7.
      csr_write(pqp_pkg::REG_PACK_MODE, 24'(pqp_pkg::MODE_NONZERO_BIT));
      csr_release();
      queue_pixel(24'hFFFFFF, 1'b0);
      queue_pixel(24'h000000, 1'b0);
      queue_pixel(24'hBFBFBF, 1'b0);
      wait_drained();
      csr_write(pqp_pkg::REG_PACK_MODE, 24'(pqp_pkg::MODE_INDEX_PAIR));
      csr_release();
      queue_pixel(24'h7F7F7F, 1'b0);
      queue_pixel(24'h7F7F7F, 1'b0);
      queue_pixel(24'h7F7F7F, 1'b0);
      wait_drained();

      // A pending bit must survive a spell in byte mode and writes to the
      // unused indexes, and then be flushed together with the next bit.
      csr_write(pqp_pkg::REG_PACK_MODE, 24'(pqp_pkg::MODE_NONZERO_BIT));
      csr_release();
      queue_pixel(24'h000000, 1'b0);
      wait_drained();
      csr_write(pqp_pkg::REG_PACK_MODE, 24'(pqp_pkg::MODE_INDEX_BYTE));
      csr_release();
      queue_pixel(24'hFFFFFF, 1'b0);
      queue_pixel(24'h808080, 1'b1);
      wait_drained();
      csr_write(3'd5, 24'h000000);
      csr_write(3'd6, 24'hFFFFFF);
      csr_write(3'd7, 24'h5A5A5A);
      csr_write(pqp_pkg::REG_PACK_MODE, 24'(pqp_pkg::MODE_RED_BIT));
      csr_release();
      queue_pixel(24'hC80000, 1'b1);

      // Random phases.
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         wait_drained();
         style = $urandom_range(0, 4);
         for (int n = 0; n < pqp_pkg::NUM_ENTRIES; n++) begin
            case (style)
               0: pal[n] = 24'($urandom);
               // Corners of the colour cube.
               1: pal[n] = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                            {8{$urandom_range(0, 1) == 1}}};
               // Pairs of equal entries: the lower one must always win.
               2: pal[n] = (n % 2 == 1) ? pal[n-1] : 24'($urandom);
               3: pal[n] = pqp_pkg::PALETTE_RESET[n];
               // All entries the same: every pixel maps to entry 0.
               default: pal[n] = (n == 0) ? 24'($urandom) : pal[0];
            endcase
         end
         csr_write(pqp_pkg::REG_PALETTE_ZERO, pal[0]);
         csr_write(pqp_pkg::REG_PALETTE_ONE, pal[1]);
         csr_write(pqp_pkg::REG_PALETTE_TWO, pal[2]);
         csr_write(pqp_pkg::REG_PALETTE_THREE, pal[3]);
         if (phase_count < 8) begin
            csr_write(pqp_pkg::REG_PACK_MODE, 24'(phase_count % 4));
         end else begin
            csr_write(pqp_pkg::REG_PACK_MODE, 24'($urandom));
         end
         if ($urandom_range(0, 3) == 0) begin
            spare_idx = 3'($urandom_range(5, 7));
            csr_write(spare_idx, 24'($urandom));
         end
         csr_release();
         phase_count++;

         // Short groups flush often; long ones mostly fill whole bytes.
         case ($urandom_range(0, 2))
            0: group_den = 2;
            1: group_den = 6;
            default: group_den = 40;
         endcase
         count = $urandom_range(60, 160);
         for (int i = 0; i < count; i++) begin
            pending_pixels.insert(pending_pixels.size(),
                                  random_pixel($urandom_range(1, group_den) == 1));
         end
         random_sent += count;
      end

      wait_drained();

      $display("Summary: %0d pixels over %0d random phases, all pack modes and palette styles",
               pixels_sent, phase_count);
      $display("Summary: %0d bytes compared, %0d closing a group, %0d mismatches",
               bytes_checked, groups_closed, fail_count);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pqp_pkg.sv
rtl/core/pqp_req_if.sv
rtl/core/pqp_rsp_if.sv
rtl/core/pqp_front.sv
rtl/core/pqp_queue.sv
rtl/core/pqp_back.sv
rtl/core/palette_quantize_pack_unit.sv
rtl/core/pqp_checker.sv
bench/palette_quantize_pack_unit_test.sv
